// File: hw/rtl/msgbi_pkg.sv
// Package: constants, codes and types of the stream group buffer index unit.
`default_nettype none

package msgbi_pkg;

    localparam int MAX_STREAMS  = 4;
    localparam int MAX_CAPACITY = 512;

    localparam int IDX_W      = $clog2(MAX_STREAMS);
    localparam int POS_W      = $clog2(MAX_CAPACITY + 1);
    localparam int GRP_W      = 32;
    localparam int CNT_W      = 3;
    localparam int CAP_W      = 10;
    localparam int MASK_W     = 4;
    localparam int SLOT_W     = 9;
    localparam int SPACE_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    // w - r + cap * diff, signed, with headroom
    localparam int LAG_W      = POS_W + GRP_W + 3;

    // command codes
    localparam logic [1:0] CMD_PUT = 2'd0;
    localparam logic [1:0] CMD_GET = 2'd1;
    localparam logic [1:0] CMD_END = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_MODE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VIDEO_MASK   = 2'd3;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EOS       = 3'd1,
        ST_NOSTREAMS = 3'd2,
        ST_BADINDEX  = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_THROTTLED = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_P_READ,
        S_P_EXEC,
        S_G_READ,
        S_G_EVAL,
        S_G_PICK,
        S_G_FINAL
    } t_state;

    // writer side entry, one per stream
    typedef struct packed {
        logic [GRP_W-1:0] grp;
        logic [POS_W-1:0] prev;
        logic [POS_W-1:0] wpos;
    } t_wr_entry;

    // reader side entry, one per stream
    typedef struct packed {
        logic [GRP_W-1:0] rgrp;
        logic [POS_W-1:0] rpos;
    } t_rd_entry;

endpackage

`default_nettype wire

// File: hw/rtl/multi_stream_gop_buffer_index_unit.sv
// Top level: group-of-pictures ring buffer index engine with one reader.
`default_nettype none

// Index engine for per-stream group-of-pictures ring buffers. A command is
// taken when i_start is high and o_busy is low; every command except the
// unused code three answers with exactly one result beat, marked by o_valid
// for one cycle, which the receiver must take as it comes. End of stream,
// error answers and a get with no streams set up are decided at acceptance:
// the result shows in the next cycle and o_busy never rises. A put reads the
// stream's writer entry in S_P_READ and writes it back in S_P_EXEC, with
// o_busy high in both; the result shows in the cycle after S_P_EXEC.
// A get walks the streams in use one at a time through the writer and
// reader memories in S_G_READ, S_G_EVAL and S_G_PICK (read, repair and
// write back, compare), then commits the chosen stream in S_G_FINAL;
// o_busy stays high throughout. The state lives in two 4-entry memories
// with registered reads; per-entry valid bits make them read as zero after
// reset, so no clearing pass is needed. Configuration writes are always
// taken (o_cfg_ready is tied high) and must only happen while idle.
module multi_stream_gop_buffer_index_unit
    import msgbi_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // command channel
    input  wire logic                  i_start,
    output logic                       o_busy,
    input  wire logic [1:0]            i_command,
    input  wire logic [2:0]            i_stream_index,
    input  wire logic                  i_key_frame,
    input  wire logic                  i_space_known,
    input  wire logic [SPACE_W-1:0]    i_out_space,
    input  wire logic [SPACE_W-1:0]    i_max_space,
    // result beat
    output logic                       o_valid,
    output logic [2:0]                 o_status,
    output logic [1:0]                 o_chosen_stream,
    output logic [SLOT_W-1:0]          o_slot,
    output logic                       o_stored,
    // configuration write channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // ---------------- registers ----------------
    t_state                r_state, n_state;

    logic [CNT_W-1:0]      r_stream_count;
    logic [CAP_W-1:0]      r_capacity;
    logic                  r_frame_mode;
    logic [MASK_W-1:0]     r_video_mask;
    logic                  r_ended;

    // captured command
    logic [IDX_W-1:0]      r_stream;
    logic                  r_key;
    logic                  r_known;
    logic [SPACE_W-1:0]    r_ospace;
    logic [SPACE_W-1:0]    r_mspace;

    // get walk
    logic [IDX_W-1:0]      r_idx;
    logic                  r_cur_cand;
    logic signed [LAG_W-1:0] r_cur_lag;
    t_rd_entry             r_cur_rd;
    logic                  r_best_vld;
    logic [IDX_W-1:0]      r_best_idx;
    logic signed [LAG_W-1:0] r_best_lag;
    t_rd_entry             r_best_rd;

    // result registers
    logic                  r_valid;
    t_status               r_status;
    logic [1:0]            r_chosen;
    logic [SLOT_W-1:0]     r_slot;
    logic                  r_stored;

    // memories
    t_wr_entry             r_wr_mem [MAX_STREAMS];
    t_rd_entry             r_rd_mem [MAX_STREAMS];
    logic [MAX_STREAMS-1:0] r_wr_vld;
    logic [MAX_STREAMS-1:0] r_rd_vld;
    t_wr_entry             r_wr_q;
    t_rd_entry             r_rd_q;
    logic                  r_wr_q_vld;
    logic                  r_rd_q_vld;

    // ---------------- live configuration ----------------
    logic [CNT_W-1:0]      live_n;
    logic [POS_W-1:0]      live_cap;
    logic                  any_audio;

    always_comb begin
        live_n = (r_stream_count > CNT_W'(MAX_STREAMS)) ? CNT_W'(MAX_STREAMS)
                                                         : r_stream_count;
        if (r_capacity == '0 || r_capacity > CAP_W'(MAX_CAPACITY)) begin
            live_cap = POS_W'(MAX_CAPACITY);
        end else begin
            live_cap = POS_W'(r_capacity);
        end
        any_audio = 1'b0;
        for (int i = 0; i < MAX_STREAMS; i++) begin
            if (CNT_W'(i) < live_n && !r_video_mask[i]) begin
                any_audio = 1'b1;
            end
        end
    end

    // memory read data, zero while an entry was never written
    t_wr_entry wr_cur;
    t_rd_entry rd_cur;
    assign wr_cur = r_wr_q_vld ? r_wr_q : '0;
    assign rd_cur = r_rd_q_vld ? r_rd_q : '0;

    // ---------------- acceptance decode ----------------
    logic accept;
    logic put_ok;
    logic get_walk;
    assign accept   = i_start && (r_state == S_IDLE);
    assign put_ok   = (i_command == CMD_PUT) && !r_ended && (live_n != '0)
                      && (i_stream_index < live_n);
    assign get_walk = (i_command == CMD_GET) && !r_ended && (live_n != '0);

    logic last_idx;
    assign last_idx = (CNT_W'(r_idx) + CNT_W'(1)) == live_n;

    // ---------------- put datapath ----------------
    logic             p_vid;
    logic             p_restart;
    t_wr_entry        p_new;
    logic [POS_W-1:0] p_w0;
    logic             p_fits;

    always_comb begin
        p_vid = r_video_mask[r_stream];
        if (r_frame_mode) begin
            p_restart = wr_cur.wpos >= live_cap;
        end else begin
            p_restart = (p_vid && r_key) || (!p_vid && wr_cur.wpos >= live_cap);
        end
        p_new = wr_cur;
        if (p_restart) begin
            p_new.prev = wr_cur.wpos;
            p_new.wpos = '0;
            p_new.grp  = wr_cur.grp + GRP_W'(1);
        end
        p_w0   = p_new.wpos;
        p_fits = p_w0 < live_cap;
        if (p_fits) begin
            p_new.wpos = p_w0 + POS_W'(1);
        end
    end

    // ---------------- get repair (one stream) ----------------
    logic [GRP_W-1:0]         g_diff;
    logic [POS_W+GRP_W-1:0]   g_prod;
    logic signed [LAG_W-1:0]  g_lag;
    logic [POS_W-1:0]         g_size;
    t_rd_entry                g_rd_new;
    logic                     g_cand;

    always_comb begin
        g_diff   = wr_cur.grp - rd_cur.rgrp;
        g_prod   = (POS_W+GRP_W)'(live_cap) * (POS_W+GRP_W)'(g_diff);
        g_rd_new = rd_cur;
        g_size   = wr_cur.wpos;
        if (g_diff == '0) begin
            g_lag = LAG_W'(wr_cur.wpos) - LAG_W'(rd_cur.rpos);
        end else if (g_diff != GRP_W'(1)) begin
            // reader lost track: resync to start of current group
            g_lag = LAG_W'(wr_cur.wpos) - LAG_W'(rd_cur.rpos) + LAG_W'(g_prod);
            g_rd_new.rgrp = wr_cur.grp;
            g_rd_new.rpos = '0;
        end else begin
            g_lag = LAG_W'(wr_cur.prev) - LAG_W'(rd_cur.rpos) + LAG_W'(wr_cur.wpos);
            if (!(wr_cur.wpos <= rd_cur.rpos && rd_cur.rpos < wr_cur.prev)) begin
                // old group already overwritten under the reader
                g_rd_new.rgrp = wr_cur.grp;
                g_rd_new.rpos = '0;
            end else begin
                g_size = wr_cur.prev;
            end
        end
        g_cand = g_rd_new.rpos < g_size;
    end

    // ---------------- pick compare ----------------
    logic c_vid;
    logic b_vid;
    logic c_take;

    always_comb begin
        c_vid  = r_video_mask[r_idx];
        b_vid  = r_video_mask[r_best_idx];
        c_take = 1'b0;
        if (r_cur_cand) begin
            if (!r_best_vld) begin
                c_take = 1'b1;
            end else if (!c_vid) begin
                c_take = b_vid || (r_cur_lag > r_best_lag);
            end else begin
                c_take = b_vid && (r_cur_lag > r_best_lag);
            end
        end
    end

    logic throttle;
    assign throttle = !r_frame_mode && any_audio && r_video_mask[r_best_idx] && r_known
                      && (r_ospace < (r_mspace >> 1)) && (r_best_rd.rpos != '0);

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && put_ok) begin
                    n_state = S_P_READ;
                end else if (accept && get_walk) begin
                    n_state = S_G_READ;
                end
            end
            S_P_READ:  n_state = S_P_EXEC;
            S_P_EXEC:  n_state = S_IDLE;
            S_G_READ:  n_state = S_G_EVAL;
            S_G_EVAL:  n_state = S_G_PICK;
            S_G_PICK:  n_state = last_idx ? S_G_FINAL : S_G_READ;
            S_G_FINAL: n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // ---------------- outputs of the sequencer ----------------
    logic             wr_re;
    logic [IDX_W-1:0] wr_raddr;
    logic             wr_we;
    logic             rd_re;
    logic             rd_we;
    logic [IDX_W-1:0] rd_waddr;
    t_rd_entry        rd_wdata;
    logic             res_en;
    t_status          res_status;
    logic [1:0]       res_chosen;
    logic [SLOT_W-1:0] res_slot;
    logic             res_stored;
    logic             set_ended;

    always_comb begin
        wr_re      = 1'b0;
        wr_raddr   = r_idx;
        wr_we      = 1'b0;
        rd_re      = 1'b0;
        rd_we      = 1'b0;
        rd_waddr   = r_idx;
        rd_wdata   = g_rd_new;
        res_en     = 1'b0;
        res_status = ST_OK;
        res_chosen = '0;
        res_slot   = '0;
        res_stored = 1'b0;
        set_ended  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_command)
                        CMD_END: begin
                            res_en    = 1'b1;
                            set_ended = 1'b1;
                        end
                        CMD_PUT: begin
                            if (r_ended) begin
                                res_en     = 1'b1;
                                res_status = ST_EOS;
                            end else if (live_n == '0) begin
                                res_en     = 1'b1;
                                res_status = ST_NOSTREAMS;
                            end else if (i_stream_index >= live_n) begin
                                res_en     = 1'b1;
                                res_status = ST_BADINDEX;
                            end
                        end
                        CMD_GET: begin
                            if (r_ended) begin
                                res_en     = 1'b1;
                                res_status = ST_EOS;
                            end else if (live_n == '0) begin
                                res_en     = 1'b1;
                                res_status = ST_EMPTY;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_P_READ: begin
                wr_re    = 1'b1;
                wr_raddr = r_stream;
            end
            S_P_EXEC: begin
                wr_we      = 1'b1;
                res_en     = 1'b1;
                res_chosen = 2'(r_stream);
                res_slot   = p_fits ? SLOT_W'(p_w0) : '0;
                res_stored = p_fits;
            end
            S_G_READ: begin
                wr_re = 1'b1;
                rd_re = 1'b1;
            end
            S_G_EVAL: begin
                // repairs are written back whatever the outcome
                rd_we = 1'b1;
            end
            S_G_FINAL: begin
                res_en = 1'b1;
                if (!r_best_vld) begin
                    res_status = ST_EMPTY;
                end else if (throttle) begin
                    res_status = ST_THROTTLED;
                    res_chosen = 2'(r_best_idx);
                end else begin
                    res_chosen    = 2'(r_best_idx);
                    res_slot      = SLOT_W'(r_best_rd.rpos);
                    rd_we         = 1'b1;
                    rd_waddr      = r_best_idx;
                    rd_wdata      = r_best_rd;
                    rd_wdata.rpos = r_best_rd.rpos + POS_W'(1);
                end
            end
            default: ;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_stream_count <= '0;
            r_capacity     <= CAP_W'(MAX_CAPACITY);
            r_frame_mode   <= 1'b0;
            r_video_mask   <= '0;
            r_ended        <= 1'b0;
            r_valid        <= 1'b0;
            r_wr_vld       <= '0;
            r_rd_vld       <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= res_en;
            if (set_ended) begin
                r_ended <= 1'b1;
            end
            if (wr_we) begin
                r_wr_vld[r_stream] <= 1'b1;
            end
            if (rd_we) begin
                r_rd_vld[rd_waddr] <= 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_STREAM_COUNT: r_stream_count <= i_cfg_data[CNT_W-1:0];
                    CFG_CAPACITY:     r_capacity     <= i_cfg_data[CAP_W-1:0];
                    CFG_FRAME_MODE:   r_frame_mode   <= i_cfg_data[0];
                    CFG_VIDEO_MASK:   r_video_mask   <= i_cfg_data[MASK_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stream   <= i_stream_index[IDX_W-1:0];
            r_key      <= i_key_frame;
            r_known    <= i_space_known;
            r_ospace   <= i_out_space;
            r_mspace   <= i_max_space;
            r_idx      <= '0;
            r_best_vld <= 1'b0;
        end
        if (r_state == S_G_EVAL) begin
            r_cur_cand <= g_cand;
            r_cur_lag  <= g_lag;
            r_cur_rd   <= g_rd_new;
        end
        if (r_state == S_G_PICK) begin
            if (c_take) begin
                r_best_vld <= 1'b1;
                r_best_idx <= r_idx;
                r_best_lag <= r_cur_lag;
                r_best_rd  <= r_cur_rd;
            end
            r_idx <= r_idx + IDX_W'(1);
        end
        if (res_en) begin
            r_status <= res_status;
            r_chosen <= res_chosen;
            r_slot   <= res_slot;
            r_stored <= res_stored;
        end
    end

    // ---------------- memories ----------------
    always_ff @(posedge i_clk) begin
        if (wr_we) begin
            r_wr_mem[r_stream] <= p_new;
        end
        if (wr_re) begin
            r_wr_q     <= r_wr_mem[wr_raddr];
            r_wr_q_vld <= r_wr_vld[wr_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_we) begin
            r_rd_mem[rd_waddr] <= rd_wdata;
        end
        if (rd_re) begin
            r_rd_q     <= r_rd_mem[r_idx];
            r_rd_q_vld <= r_rd_vld[r_idx];
        end
    end

    // ---------------- ports ----------------
    assign o_busy          = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_chosen_stream = r_chosen;
    assign o_slot          = r_slot;
    assign o_stored        = r_stored;
    assign o_cfg_ready     = 1'b1;

`ifndef SYNTH
    // error answers carry no slot and no store
    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK && o_status != ST_THROTTLED)
            |-> (o_slot == '0 && o_stored == 1'b0 && o_chosen_stream == '0))
        else $error("error result with nonzero fields");

    // a slot is only granted with an ok status
    a_stored_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_stored) |-> (o_status == ST_OK))
        else $error("stored set on non-ok result");

    // the walk never reaches a stream that is not in use
    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_G_READ) |-> (CNT_W'(r_idx) < live_n))
        else $error("get walk past streams in use");

    // a put result follows its memory read, with S_P_EXEC between the two
    a_put_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_P_READ) |=> (r_state == S_P_EXEC) ##1 o_valid)
        else $error("put result not delivered in time");
`endif

endmodule

`default_nettype wire

// File: verif/tb_multi_stream_gop_buffer_index_unit.sv
// Testbench: self-checking random and directed test of the GOP buffer index unit.
module tb_multi_stream_gop_buffer_index_unit;
    import msgbi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Unused command code: the block takes it and answers nothing.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int NUM_PHASES      = 9;
    localparam int ITEMS_PER_PHASE = 200;
    // Slowest legal quiet stretch is a get walk over four streams plus a long
    // sender gap or a settle pause; this limit is far above that.
    localparam int WATCHDOG_LIMIT  = 2000;

    // One command beat as driven on the command channel.
    typedef struct packed {
        logic [1:0]         command;
        logic [2:0]         stream;
        logic               key;
        logic               known;
        logic [SPACE_W-1:0] out_space;
        logic [SPACE_W-1:0] max_space;
    } t_cmd_beat;

    // One result beat.
    typedef struct packed {
        logic [2:0]        status;
        logic [1:0]        stream;
        logic [SLOT_W-1:0] slot;
        logic              stored;
    } t_answer;

    // Shadow of the writer/reader indexes plus the queue of answers still owed.
    class slot_index_scoreboard;
        bit [CNT_W-1:0]  cfg_count;
        bit [CAP_W-1:0]  cfg_cap = CAP_W'(MAX_CAPACITY);
        bit              cfg_frame;
        bit [MASK_W-1:0] cfg_video;

        bit [POS_W-1:0]  wr_pos    [MAX_STREAMS];
        bit [POS_W-1:0]  prev_size [MAX_STREAMS];
        bit [GRP_W-1:0]  grp       [MAX_STREAMS];
        bit [GRP_W-1:0]  rd_grp    [MAX_STREAMS];
        bit [POS_W-1:0]  rd_pos    [MAX_STREAMS];
        bit              ended;

        t_answer answer_q [$];
        int      errors;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_STREAM_COUNT: cfg_count = data[CNT_W-1:0];
                CFG_CAPACITY:     cfg_cap   = data[CAP_W-1:0];
                CFG_FRAME_MODE:   cfg_frame = data[0];
                CFG_VIDEO_MASK:   cfg_video = data[MASK_W-1:0];
                default: ;
            endcase
        endfunction

        function bit is_video(int unsigned s);
            return (s < MASK_W) && cfg_video[s];
        endfunction

        // Work out the answer to an accepted command and queue it.
        function void note_command(t_cmd_beat c);
            t_answer     a;
            int unsigned n;
            int unsigned cap;
            int unsigned s;
            longint      capl;
            longint      lag [MAX_STREAMS];
            longint      w;
            longint      r;
            longint      old;
            longint      size;
            longint      dl;
            bit [31:0]   diff;
            int          best;
            bit          audio_seen;

            n    = (cfg_count > MAX_STREAMS) ? MAX_STREAMS : cfg_count;
            cap  = (cfg_cap == 0 || cfg_cap > MAX_CAPACITY) ? MAX_CAPACITY : cfg_cap;
            capl = cap;
            s    = c.stream;
            a    = '0;
            a.status = ST_OK;

            if (c.command == CMD_UNUSED) return;

            if (c.command == CMD_END) begin
                ended = 1'b1;
            end else if (ended) begin
                a.status = ST_EOS;
            end else if (c.command == CMD_PUT) begin
                if (n == 0) begin
                    a.status = ST_NOSTREAMS;
                end else if (s >= n) begin
                    a.status = ST_BADINDEX;
                end else begin
                    // frame mode: restart on full; packet mode: video on key, audio on full
                    if (cfg_frame ? (wr_pos[s] >= cap)
                                  : (is_video(s) ? c.key : (wr_pos[s] >= cap))) begin
                        prev_size[s] = wr_pos[s];
                        wr_pos[s]    = '0;
                        grp[s]       = grp[s] + 1;
                    end
                    a.stream = s[1:0];
                    if (wr_pos[s] < cap) begin
                        a.slot    = wr_pos[s][SLOT_W-1:0];
                        a.stored  = 1'b1;
                        wr_pos[s] = wr_pos[s] + 1;
                    end
                end
            end else begin
                best       = -1;
                audio_seen = 1'b0;
                for (int i = 0; i < n; i++) begin
                    if (!is_video(i)) audio_seen = 1'b1;
                    w    = wr_pos[i];
                    old  = prev_size[i];
                    r    = rd_pos[i];
                    diff = grp[i] - rd_grp[i];
                    dl   = diff;
                    if (diff == 0) begin
                        size   = w;
                        lag[i] = w - r;
                    end else if (diff != 1) begin
                        // reader lost: jump to start of current group
                        lag[i]    = w - r + capl * dl;
                        rd_grp[i] = grp[i];
                        rd_pos[i] = '0;
                        size      = w;
                    end else if (!(w <= r && r < old)) begin
                        // one group behind but overwritten by the writer
                        lag[i]    = old - r + w;
                        rd_grp[i] = grp[i];
                        rd_pos[i] = '0;
                        size      = w;
                    end else begin
                        lag[i] = old - r + w;
                        size   = old;
                    end
                    r = rd_pos[i];
                    if (r < size) begin
                        if (best < 0) begin
                            best = i;
                        end else if (!is_video(i)) begin
                            if (is_video(best) || lag[i] > lag[best]) best = i;
                        end else if (is_video(best) && lag[i] > lag[best]) begin
                            best = i;
                        end
                    end
                end
                if (best < 0) begin
                    a.status = ST_EMPTY;
                end else begin
                    a.stream = best[1:0];
                    if (!cfg_frame && audio_seen && is_video(best) && c.known &&
                        c.out_space < c.max_space / 2 && rd_pos[best] > 0) begin
                        a.status = ST_THROTTLED;
                    end else begin
                        a.slot       = rd_pos[best][SLOT_W-1:0];
                        rd_pos[best] = rd_pos[best] + 1;
                    end
                end
            end
            answer_q.push_back(a);
        endfunction

        function void check_answer(t_answer got);
            t_answer want;
            if (answer_q.size() == 0) begin
                $error("result beat with no command pending: status %0d", got.status);
                errors++;
                return;
            end
            want = answer_q.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.stream !== want.stream) begin
                $error("chosen_stream: expected %0d, got %0d", want.stream, got.stream);
                errors++;
            end
            if (got.slot !== want.slot) begin
                $error("slot: expected %0d, got %0d", want.slot, got.slot);
                errors++;
            end
            if (got.stored !== want.stored) begin
                $error("stored: expected %0d, got %0d", want.stored, got.stored);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    logic [1:0]            i_command;
    logic [2:0]            i_stream_index;
    logic                  i_key_frame;
    logic                  i_space_known;
    logic [SPACE_W-1:0]    i_out_space;
    logic [SPACE_W-1:0]    i_max_space;
    logic                  o_valid;
    logic [2:0]            o_status;
    logic [1:0]            o_chosen_stream;
    logic [SLOT_W-1:0]     o_slot;
    logic                  o_stored;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    slot_index_scoreboard sb = new;
    int                   quiet_cycles = 0;

    multi_stream_gop_buffer_index_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_command       (i_command),
        .i_stream_index  (i_stream_index),
        .i_key_frame     (i_key_frame),
        .i_space_known   (i_space_known),
        .i_out_space     (i_out_space),
        .i_max_space     (i_max_space),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_chosen_stream (o_chosen_stream),
        .o_slot          (o_slot),
        .o_stored        (o_stored),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // 20 ns period
    always #10 i_clk = ~i_clk;

    // Result beats cannot be held off: check every strobe as it comes.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_answer(t_answer'{o_status, o_chosen_stream, o_slot, o_stored});
    end

    // Watchdog: any accepted beat on any channel resets the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_multi_stream_gop_buffer_index_unit failed");
            $finish;
        end
    end

    function automatic t_cmd_beat cmd_beat(logic [1:0] command, logic [2:0] stream,
                                           logic key, logic known,
                                           logic [SPACE_W-1:0] out_space,
                                           logic [SPACE_W-1:0] max_space);
        return t_cmd_beat'{command, stream, key, known, out_space, max_space};
    endfunction

    // Random command; put_bias is the put share in percent, a few percent are
    // the unused code. Most stream indexes land on streams in use.
    function automatic t_cmd_beat rand_cmd(int unsigned live, int unsigned put_bias);
        t_cmd_beat   c;
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 2)
            c.command = CMD_UNUSED;
        else if (roll < 2 + put_bias * 98 / 100)
            c.command = CMD_PUT;
        else
            c.command = CMD_GET;
        if (live == 0 || $urandom_range(9) == 0)
            c.stream = 3'($urandom_range(7));
        else
            c.stream = 3'($urandom_range(live - 1));
        c.key       = ($urandom_range(6) == 0);
        c.known     = 1'($urandom_range(1));
        c.max_space = ($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom);
        c.out_space = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(c.max_space));
        return c;
    endfunction

    // Present a command at the falling edge, hold it until taken. start is
    // left high so a following beat can go out back to back.
    task automatic send_cmd(input t_cmd_beat c);
        @(negedge i_clk);
        i_start        = 1'b1;
        i_command      = c.command;
        i_stream_index = c.stream;
        i_key_frame    = c.key;
        i_space_known  = c.known;
        i_out_space    = c.out_space;
        i_max_space    = c.max_space;
        do @(posedge i_clk); while (o_busy);
        sb.note_command(c);
    endtask

    task automatic idle_cycle();
        @(negedge i_clk);
        i_start = 1'b0;
    endtask

    // Stop sending, wait for every owed answer, then let tail cycles pass.
    task automatic drain(input int tail);
        @(negedge i_clk);
        i_start = 1'b0;
        while (sb.answer_q.size() != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    initial begin
        t_cmd_beat       c;
        int unsigned     idle_pct;
        int unsigned     sent;
        int unsigned     put_bias;
        int unsigned     live;
        logic [CNT_W-1:0]  cnt;
        logic [CAP_W-1:0]  cap;
        logic              fm;
        logic [MASK_W-1:0] vm;

        i_rst_n        = 1'b0;
        i_start        = 1'b0;
        i_command      = CMD_PUT;
        i_stream_index = '0;
        i_key_frame    = 1'b0;
        i_space_known  = 1'b0;
        i_out_space    = '0;
        i_max_space    = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_STREAM_COUNT;
        i_cfg_data     = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // --- directed ---
        // reset config: no streams set up
        send_cmd(cmd_beat(CMD_PUT, 3'd0, 1'b0, 1'b0, 16'h0000, 16'h0000));
        send_cmd(cmd_beat(CMD_GET, 3'd0, 1'b0, 1'b1, 16'h0000, 16'hFFFF));
        send_cmd(cmd_beat(CMD_UNUSED, 3'd0, 1'b0, 1'b0, 16'h0000, 16'h0000));
        drain(16);
        // four streams, capacity 3, packet mode, streams 1 and 3 video
        write_reg(CFG_STREAM_COUNT, 10'd4);
        write_reg(CFG_CAPACITY, 10'd3);
        write_reg(CFG_FRAME_MODE, 10'd0);
        write_reg(CFG_VIDEO_MASK, 10'b1010);
        // audio fills its group, fourth put forces a restart
        repeat (4) send_cmd(cmd_beat(CMD_PUT, 3'd0, 1'b0, 1'b0, 16'h0000, 16'h0000));
        // video restarts on key, then runs past capacity and gets dropped
        send_cmd(cmd_beat(CMD_PUT, 3'd1, 1'b1, 1'b0, 16'h0000, 16'h0000));
        repeat (4) send_cmd(cmd_beat(CMD_PUT, 3'd1, 1'b0, 1'b0, 16'h0000, 16'h0000));
        // bad stream indexes, then a put to stream 3, the last one in use
        send_cmd(cmd_beat(CMD_PUT, 3'd7, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF));
        send_cmd(cmd_beat(CMD_PUT, 3'd4, 1'b0, 1'b0, 16'h0000, 16'h0000));
        send_cmd(cmd_beat(CMD_PUT, 3'd3, 1'b0, 1'b0, 16'h0000, 16'h0000));
        // reads under low output space: audio first, video then throttled
        repeat (6) send_cmd(cmd_beat(CMD_GET, 3'd0, 1'b0, 1'b1, 16'h0000, 16'hFFFF));
        send_cmd(cmd_beat(CMD_GET, 3'd0, 1'b0, 1'b0, 16'h0000, 16'hFFFF));
        send_cmd(cmd_beat(CMD_GET, 3'd7, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF));
        send_cmd(cmd_beat(CMD_PUT, 3'd2, 1'b1, 1'b1, 16'hFFFF, 16'h0000));
        send_cmd(cmd_beat(CMD_GET, 3'd0, 1'b0, 1'b1, 16'h7FFE, 16'hFFFF));

        // --- random phases, one register setting each ---
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin cnt = 3'd4; cap = 10'd3;    fm = 1'b0; vm = 4'b1010; end
                1: begin cnt = 3'd2; cap = 10'd1;    fm = 1'b0; vm = 4'b0011; end
                2: begin cnt = 3'd7; cap = 10'd0;    fm = 1'b1; vm = 4'b0101; end
                3: begin cnt = 3'd1; cap = 10'd2;    fm = 1'b0; vm = 4'b0001; end
                4: begin cnt = 3'd4; cap = 10'd1023; fm = 1'b0; vm = 4'b1111; end
                5: begin cnt = 3'd3; cap = 10'd5;    fm = 1'b1; vm = 4'b0000; end
                6: begin cnt = 3'd4; cap = 10'd4;    fm = 1'b0; vm = 4'b1000; end
                7: begin cnt = 3'd5; cap = 10'd512;  fm = 1'b0; vm = 4'b0110; end
                default: begin cnt = 3'd4; cap = 10'd2; fm = 1'b1; vm = 4'b1111; end
            endcase
            live = (cnt > MAX_STREAMS) ? MAX_STREAMS : cnt;
            // only write while idle; upper data bits are don't-care noise
            drain(16);
            write_reg(CFG_STREAM_COUNT, {7'($urandom), cnt});
            write_reg(CFG_CAPACITY, cap);
            write_reg(CFG_FRAME_MODE, {9'($urandom), fm});
            write_reg(CFG_VIDEO_MASK, {6'($urandom), vm});

            // sender gaps: 31% first, then 77%, then none
            idle_pct = (p < 3) ? 31 : (p < 6) ? 77 : 0;
            sent     = 0;
            put_bias = 50;
            while (sent < ITEMS_PER_PHASE) begin
                // bursts of puts or gets so readers fall groups behind or catch up
                if (sent % 16 == 0) begin
                    case ($urandom_range(2))
                        0: put_bias = 20;
                        1: put_bias = 50;
                        default: put_bias = 85;
                    endcase
                end
                c = rand_cmd(live, put_bias);
                while ($urandom_range(99) < idle_pct) idle_cycle();
                send_cmd(c);
                if (c.command != CMD_UNUSED) sent++;
                // occasionally hold off until every answer is back
                if ($urandom_range(99) == 0) drain(0);
            end
        end

        // --- end of stream: latched until reset ---
        send_cmd(cmd_beat(CMD_PUT, 3'd0, 1'b0, 1'b0, 16'h0000, 16'h0000));
        send_cmd(cmd_beat(CMD_END, 3'd5, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF));
        send_cmd(cmd_beat(CMD_PUT, 3'd0, 1'b0, 1'b0, 16'h0000, 16'h0000));
        send_cmd(cmd_beat(CMD_GET, 3'd0, 1'b0, 1'b1, 16'h0000, 16'hFFFF));
        send_cmd(cmd_beat(CMD_UNUSED, 3'd0, 1'b0, 1'b0, 16'h0000, 16'h0000));
        send_cmd(cmd_beat(CMD_END, 3'd0, 1'b0, 1'b0, 16'h0000, 16'h0000));
        send_cmd(cmd_beat(CMD_PUT, 3'd5, 1'b0, 1'b0, 16'h0000, 16'h0000));

        drain(32);
        if (sb.errors == 0)
            $display("tb_multi_stream_gop_buffer_index_unit passed");
        else
            $display("tb_multi_stream_gop_buffer_index_unit failed");
        $finish;
    end

endmodule
